[rtl/core/joystick_rate_servo_jog_unit_macros.svh]
// ----------------------------------------------------------------------------
// joystick rate servo jog unit assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RATE_SERVO_JOG_UNIT_MACROS_SVH
`define JOYSTICK_RATE_SERVO_JOG_UNIT_MACROS_SVH

`ifndef SYNTH
`define JRSJ_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define JRSJ_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define JRSJ_ASSERT(name, cond, msg)
`define JRSJ_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[rtl/core/jrsj_pkg.sv]
// ----------------------------------------------------------------------------
// jrsj_pkg
// types, constants and the step interval function of the servo jog unit
// ----------------------------------------------------------------------------
package jrsj_pkg;

	localparam int NUM_AXES     = 4;
	localparam int STICK_INPUTS = 4;
	localparam int LANES        = (NUM_AXES < STICK_INPUTS) ? NUM_AXES : STICK_INPUTS;
	localparam int MASK_W       = 5;
	localparam int CLAW_BIT     = 4;

	localparam int STICK_W = 10;
	localparam int ANGLE_W = 7;
	localparam int TIME_W  = 32;
	localparam int IVL_W   = 10;
	localparam int MAG_W   = 10;
	localparam int PROD_W  = 20;
	localparam int PART_W  = 11;

	localparam int SLOW_INTERVAL   = 800;
	localparam int FAST_INTERVAL   = 250;
	localparam int FULL_SCALE_LOG2 = 9;
	localparam int FULL_SCALE      = 1 << FULL_SCALE_LOG2;
	localparam int PRESS_LOCKOUT   = 500;
	localparam int CLAW_PERIOD     = 250;

	typedef logic signed [STICK_W-1:0] stick_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [TIME_W-1:0]         time_t;
	typedef logic [IVL_W-1:0]          ivl_t;

	localparam angle_t CLAW_OPEN_LIMIT  = 7'sd60;
	localparam angle_t CLAW_CLOSE_LIMIT = -7'sd30;
	localparam angle_t MIN_ANGLE_RESET  = -7'sd60;
	localparam angle_t MAX_ANGLE_RESET  = 7'sd60;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ANGLE = 1'b0,
		REG_MAX_ANGLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		angle_t angle;
		logic   step;
	} lane_out_t;

	typedef struct packed {
		angle_t claw;
		logic   opening;
		logic   step;
	} claw_out_t;

	// 800 - ceil(|x| * 550 / 512)
	function automatic ivl_t step_interval(stick_t x);
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [PART_W-1:0] part;
		mag  = x[STICK_W-1] ? MAG_W'(-x) : MAG_W'(x);
		prod = PROD_W'(mag) * PROD_W'(SLOW_INTERVAL - FAST_INTERVAL);
		part = PART_W'((prod + PROD_W'(FULL_SCALE - 1)) >> FULL_SCALE_LOG2);
		return IVL_W'(PART_W'(SLOW_INTERVAL) - part);
	endfunction

endpackage

[rtl/core/jrsj_lane.sv]
// ----------------------------------------------------------------------------
// jrsj_lane
// one joint axis: step interval, elapsed time check, angle step and clamp
// ----------------------------------------------------------------------------
module jrsj_lane import jrsj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  stick_t    x,
	input  logic      adv,
	input  time_t     now,
	input  angle_t    min_angle,
	input  angle_t    max_angle,
	output lane_out_t res
);

	stick_t x_s1;
	ivl_t   ivl_s1;
	angle_t angle_q;
	time_t  last_q;

	time_t                    elapsed;
	logic                     fire;
	logic signed [ANGLE_W:0]  sum;
	logic signed [ANGLE_W:0]  lo;
	logic signed [ANGLE_W:0]  hi;
	logic signed [ANGLE_W:0]  clamped;

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1   <= x;
			ivl_s1 <= step_interval(x);
		end
	end

	always_comb begin
		elapsed = now - last_q;
		fire    = (x_s1 != '0) && (elapsed >= TIME_W'(ivl_s1));
		sum     = (ANGLE_W+1)'(angle_q) + (x_s1[STICK_W-1] ? -8'sd1 : 8'sd1);
		lo      = (ANGLE_W+1)'(min_angle);
		hi      = (ANGLE_W+1)'(max_angle);
		clamped = sum;
		if (clamped > hi) begin
			clamped = hi;
		end
		if (clamped < lo) begin
			clamped = lo;
		end
		res.angle = fire ? angle_t'(clamped[ANGLE_W-1:0]) : angle_q;
		res.step  = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			last_q  <= '0;
		end else if (adv && fire) begin
			angle_q <= res.angle;
			last_q  <= now;
		end
	end

endmodule

[rtl/core/jrsj_claw.sv]
// ----------------------------------------------------------------------------
// jrsj_claw
// button edge with press lockout, claw direction and periodic claw ramp
// ----------------------------------------------------------------------------
module jrsj_claw import jrsj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      button,
	input  logic      adv,
	input  time_t     now,
	output claw_out_t res
);

	logic   button_s1;
	time_t  press_q;
	time_t  last_q;
	logic   prev_q;
	logic   dir_q;
	angle_t claw_q;

	time_t since_press;
	time_t since_ramp;
	logic  toggle;
	logic  dir_n;
	logic  ramp;

	always_ff @(posedge clk) begin
		if (load) begin
			button_s1 <= button;
		end
	end

	always_comb begin
		since_press = now - press_q;
		since_ramp  = now - last_q;
		toggle      = button_s1 && !prev_q && (since_press >= TIME_W'(PRESS_LOCKOUT));
		dir_n       = dir_q ^ toggle;
		ramp        = since_ramp >= TIME_W'(CLAW_PERIOD);
		res.claw    = claw_q;
		if (ramp) begin
			if (dir_n) begin
				if (claw_q < CLAW_OPEN_LIMIT) begin
					res.claw = claw_q + 7'sd1;
				end
			end else begin
				if (claw_q > CLAW_CLOSE_LIMIT) begin
					res.claw = claw_q - 7'sd1;
				end
			end
		end
		res.opening = dir_n;
		res.step    = ramp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= '0;
			last_q  <= '0;
			prev_q  <= 1'b0;
			dir_q   <= 1'b0;
			claw_q  <= '0;
		end else if (adv) begin
			prev_q <= button_s1;
			dir_q  <= dir_n;
			if (toggle) begin
				press_q <= now;
			end
			if (ramp) begin
				claw_q <= res.claw;
				last_q <= now;
			end
		end
	end

endmodule

[rtl/core/joystick_rate_servo_jog_unit.sv]
// ----------------------------------------------------------------------------
// joystick_rate_servo_jog_unit
// four joint axes jogged at a deflection dependent rate, plus a claw ramp
// ----------------------------------------------------------------------------
// each input word is one timer tick: four stick deflections and the button
// level. each accepted word gives exactly one output word with the four joint
// angles, the claw angle, the claw direction and a mask of servos moved.
// stage 1 registers the deflections and works out each axis step interval;
// stage 2 has one lane per axis plus the claw unit, all updating their state
// in the same cycle, and the merge registers the output word.
// throughput: one word per cycle while out_stall is low; the lanes update
// their state on each advance (32-bit elapsed tick compare and angle clamp).
// when out_stall holds the output word, stage 1 still takes one more word;
// in_stall rises only once both stages are full.
// reset clears the tick counter, the angles, the claw state and both
// pipeline valids; min_angle and max_angle return to -60 and 60.
// cfg_we writes min_angle (index 0) or max_angle (index 1); the user must
// write only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "joystick_rate_servo_jog_unit_macros.svh"

module joystick_rate_servo_jog_unit import jrsj_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [ANGLE_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [STICK_W-1:0] stick1_x,
	input  logic signed [STICK_W-1:0] stick1_y,
	input  logic signed [STICK_W-1:0] stick2_x,
	input  logic signed [STICK_W-1:0] stick2_y,
	input  logic                      button,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [ANGLE_W-1:0] angle0,
	output logic signed [ANGLE_W-1:0] angle1,
	output logic signed [ANGLE_W-1:0] angle2,
	output logic signed [ANGLE_W-1:0] angle3,
	output logic signed [ANGLE_W-1:0] claw,
	output logic                      opening,
	output logic [MASK_W-1:0]         update_mask
);

	logic   s1_valid_s1;
	logic   res_valid_q;
	time_t  now_q;
	angle_t min_q;
	angle_t max_q;

	angle_t            angle_res_q [STICK_INPUTS];
	angle_t            claw_res_q;
	logic              opening_res_q;
	logic [MASK_W-1:0] mask_res_q;

	logic      load;
	logic      adv;
	stick_t    stick_in [STICK_INPUTS];
	angle_t    angle_nx [STICK_INPUTS];
	logic      step_nx  [STICK_INPUTS];
	claw_out_t claw_res;

	assign adv      = s1_valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && res_valid_q && out_stall;
	assign load     = in_valid && !in_stall;

	assign stick_in[0] = stick1_x;
	assign stick_in[1] = stick1_y;
	assign stick_in[2] = stick2_x;
	assign stick_in[3] = stick2_y;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_ANGLE_RESET;
			max_q <= MAX_ANGLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_ANGLE: min_q <= angle_t'(cfg_data);
				REG_MAX_ANGLE: max_q <= angle_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// pipeline control and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			now_q       <= '0;
		end else begin
			if (load) begin
				s1_valid_s1 <= 1'b1;
			end else if (adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
				now_q       <= now_q + TIME_W'(1);
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < STICK_INPUTS; g++) begin : g_axis
			if (g < LANES) begin : g_lane
				lane_out_t lane_res;

				jrsj_lane u_lane (
					.clk       (clk),
					.arst_n    (arst_n),
					.load      (load),
					.x         (stick_in[g]),
					.adv       (adv),
					.now       (now_q),
					.min_angle (min_q),
					.max_angle (max_q),
					.res       (lane_res)
				);

				assign angle_nx[g] = lane_res.angle;
				assign step_nx[g]  = lane_res.step;
			end else begin : g_none
				assign angle_nx[g] = '0;
				assign step_nx[g]  = 1'b0;
			end
		end
	endgenerate

	jrsj_claw u_claw (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.button (button),
		.adv    (adv),
		.now    (now_q),
		.res    (claw_res)
	);

	// merge into the output word
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < STICK_INPUTS; i++) begin
				angle_res_q[i]   <= angle_nx[i];
				mask_res_q[i]    <= step_nx[i];
			end
			mask_res_q[CLAW_BIT] <= claw_res.step;
			claw_res_q           <= claw_res.claw;
			opening_res_q        <= claw_res.opening;
		end
	end

	assign out_valid   = res_valid_q;
	assign angle0      = angle_res_q[0];
	assign angle1      = angle_res_q[1];
	assign angle2      = angle_res_q[2];
	assign angle3      = angle_res_q[3];
	assign claw        = claw_res_q;
	assign opening     = opening_res_q;
	assign update_mask = mask_res_q;

	`JRSJ_ASSERT(a_claw_range, out_valid |-> (claw >= CLAW_CLOSE_LIMIT && claw <= CLAW_OPEN_LIMIT), "claw angle out of range")
	`JRSJ_ASSERT(a_stall_cause, in_stall |-> (s1_valid_s1 && out_valid), "input stalled with a free stage")
	`JRSJ_ASSERT_NEXT(a_adv_word, adv, out_valid, "advanced word not presented")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: joystick rate servo jog unit testbench
// drives tick words through the valid/stall input channel with random gaps,
// stalls the output channel at random and checks every output word against
// a scoreboard that predicts the joint angles, claw ramp and update mask.
// clamp registers are rewritten between phases while the unit is drained.
// ----------------------------------------------------------------------------
module tb;
	import jrsj_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		stick_t s1x;
		stick_t s1y;
		stick_t s2x;
		stick_t s2y;
		logic   btn;
	} tick_in_t;

	typedef struct packed {
		angle_t          a0;
		angle_t          a1;
		angle_t          a2;
		angle_t          a3;
		angle_t          claw_pos;
		logic            open_dir;
		logic [MASK_W-1:0] mask;
	} tick_out_t;

	class jog_scoreboard;
		time_t     tick_now;
		time_t     step_stamp[NUM_AXES+1];
		angle_t    joint[NUM_AXES];
		angle_t    claw_pos;
		time_t     last_press;
		logic      prev_button;
		logic      dir_open;
		angle_t    lo_clamp;
		angle_t    hi_clamp;
		tick_out_t expected_q[$];
		int        errors;

		function new();
			tick_now   = '0;
			for (int i = 0; i <= NUM_AXES; i++) step_stamp[i] = '0;
			for (int i = 0; i < NUM_AXES; i++) joint[i] = '0;
			claw_pos    = '0;
			last_press  = '0;
			prev_button = 1'b0;
			dir_open    = 1'b0;
			lo_clamp    = MIN_ANGLE_RESET;
			hi_clamp    = MAX_ANGLE_RESET;
			errors      = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, angle_t v);
			if (idx == REG_MIN_ANGLE)
				lo_clamp = v;
			else
				hi_clamp = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int unsigned jog_interval(stick_t x);
			int mag;
			mag = (x < 0) ? -int'(x) : int'(x);
			return SLOW_INTERVAL - (mag * (SLOW_INTERVAL - FAST_INTERVAL) + FULL_SCALE - 1)
				/ FULL_SCALE;
		endfunction

		function void note_tick(tick_in_t t);
			stick_t    defl[STICK_INPUTS];
			angle_t    shown[STICK_INPUTS];
			time_t     now;
			logic [MASK_W-1:0] mask;
			int        a;
			stick_t    x;
			tick_out_t exp_word;
			now     = tick_now;
			mask    = '0;
			defl[0] = t.s1x;
			defl[1] = t.s1y;
			defl[2] = t.s2x;
			defl[3] = t.s2y;

			if (t.btn && !prev_button && time_t'(now - last_press) >= time_t'(PRESS_LOCKOUT)) begin
				dir_open   = !dir_open;
				last_press = now;
			end
			prev_button = t.btn;

			for (int i = 0; i < NUM_AXES; i++) begin
				x = (i < STICK_INPUTS) ? defl[i] : stick_t'(0);
				if (x != 0 && time_t'(now - step_stamp[i]) >= time_t'(jog_interval(x))) begin
					a = int'(joint[i]) + ((x > 0) ? 1 : -1);
					if (a > int'(hi_clamp)) a = int'(hi_clamp);
					if (a < int'(lo_clamp)) a = int'(lo_clamp);
					joint[i]      = angle_t'(a);
					step_stamp[i] = now;
					if (i < STICK_INPUTS) mask[i] = 1'b1;
				end
			end

			if (time_t'(now - step_stamp[NUM_AXES]) >= time_t'(CLAW_PERIOD)) begin
				if (dir_open) begin
					if (claw_pos < CLAW_OPEN_LIMIT) claw_pos = claw_pos + angle_t'(1);
				end else begin
					if (claw_pos > CLAW_CLOSE_LIMIT) claw_pos = claw_pos - angle_t'(1);
				end
				step_stamp[NUM_AXES] = now;
				mask[CLAW_BIT]       = 1'b1;
			end

			for (int i = 0; i < STICK_INPUTS; i++)
				shown[i] = (i < NUM_AXES) ? joint[i] : angle_t'(0);
			exp_word.a0       = shown[0];
			exp_word.a1       = shown[1];
			exp_word.a2       = shown[2];
			exp_word.a3       = shown[3];
			exp_word.claw_pos = claw_pos;
			exp_word.open_dir = dir_open;
			exp_word.mask     = mask;
			expected_q.push_back(exp_word);
			tick_now = now + time_t'(1);
		endfunction

		function void cmp_field(string name, logic signed [7:0] e, logic signed [7:0] a);
			if (e !== a) begin
				$error("%s mismatch: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(tick_out_t got);
			tick_out_t e;
			if (expected_q.size() == 0) begin
				$error("output word with nothing expected");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp_field("angle0", e.a0, got.a0);
			cmp_field("angle1", e.a1, got.a1);
			cmp_field("angle2", e.a2, got.a2);
			cmp_field("angle3", e.a3, got.a3);
			cmp_field("claw", e.claw_pos, got.claw_pos);
			cmp_field("opening", {7'd0, e.open_dir}, {7'd0, got.open_dir});
			cmp_field("update_mask", {3'd0, e.mask}, {3'd0, got.mask});
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [ANGLE_W-1:0]    cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [STICK_W-1:0] stick1_x;
	logic signed [STICK_W-1:0] stick1_y;
	logic signed [STICK_W-1:0] stick2_x;
	logic signed [STICK_W-1:0] stick2_y;
	logic                  button;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [ANGLE_W-1:0] angle0;
	logic signed [ANGLE_W-1:0] angle1;
	logic signed [ANGLE_W-1:0] angle2;
	logic signed [ANGLE_W-1:0] angle3;
	logic signed [ANGLE_W-1:0] claw;
	logic                  opening;
	logic [MASK_W-1:0]     update_mask;

	jog_scoreboard sb;
	bit            calm;
	logic          btn_level;
	int            cycle_count;

	joystick_rate_servo_jog_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stick1_x    (stick1_x),
		.stick1_y    (stick1_y),
		.stick2_x    (stick2_x),
		.stick2_y    (stick2_y),
		.button      (button),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.angle0      (angle0),
		.angle1      (angle1),
		.angle2      (angle2),
		.angle3      (angle3),
		.claw        (claw),
		.opening     (opening),
		.update_mask (update_mask)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 20);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({angle0, angle1, angle2, angle3, claw, opening, update_mask});
	end

	task automatic send_tick(tick_in_t t);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stick1_x <= t.s1x;
		stick1_y <= t.s1y;
		stick2_x <= t.s2x;
		stick2_y <= t.s2y;
		button   <= t.btn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= angle_t'(val);
		sb.set_reg(idx, angle_t'(val));
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_clamps(int lo, int hi);
		drain();
		write_reg(REG_MIN_ANGLE, lo);
		write_reg(REG_MAX_ANGLE, hi);
	endtask

	function automatic stick_t rand_stick(int ext_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ext_pct) return $urandom_range(0, 1) ? stick_t'(511) : stick_t'(-512);
		if (r < ext_pct + 10) return stick_t'(0);
		if (r < ext_pct + 20) return stick_t'(int'($urandom_range(0, 15)) - 8);
		return stick_t'($urandom_range(0, 1023));
	endfunction

	task automatic run_ticks(int n, int ext_pct, int btn_rate, int calm_len, int pause_at);
		tick_in_t t;
		for (int k = 0; k < n; k++) begin
			calm = (k < calm_len);
			if (k == pause_at) drain();
			if (btn_rate > 0 && $urandom_range(1, btn_rate) == 1) btn_level = ~btn_level;
			t.s1x = rand_stick(ext_pct);
			t.s1y = rand_stick(ext_pct);
			t.s2x = rand_stick(ext_pct);
			t.s2y = rand_stick(ext_pct);
			t.btn = btn_level;
			send_tick(t);
		end
		calm = 1'b0;
	endtask

	initial begin
		tick_in_t directed[$];
		sb        = new();
		calm      = 1'b0;
		btn_level = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MIN_ANGLE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		stick1_x  = '0;
		stick1_y  = '0;
		stick2_x  = '0;
		stick2_y  = '0;
		button    = 1'b0;
		out_stall = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// extremes, direction changes and a press inside the early lockout
		directed.push_back({10'sd0, 10'sd0, 10'sd0, 10'sd0, 1'b0});
		directed.push_back({10'sd511, -10'sd512, 10'sd1, -10'sd1, 1'b1});
		directed.push_back({-10'sd512, 10'sd511, -10'sd1, 10'sd1, 1'b1});
		directed.push_back({10'sd1, -10'sd1, 10'sd511, -10'sd512, 1'b0});
		directed.push_back({-10'sd1, 10'sd1, -10'sd512, 10'sd511, 1'b1});
		directed.push_back({10'sd256, -10'sd256, 10'sd100, -10'sd100, 1'b0});
		directed.push_back({-10'sd341, 10'sd170, 10'sd0, 10'sd2, 1'b1});
		directed.push_back({10'sd0, 10'sd0, 10'sd0, 10'sd0, 1'b0});
		directed.push_back({10'sd511, 10'sd511, 10'sd511, 10'sd511, 1'b0});
		directed.push_back({-10'sd512, -10'sd512, -10'sd512, -10'sd512, 1'b0});
		foreach (directed[i]) send_tick(directed[i]);

		// long run with the button released so the claw keeps closing
		run_ticks(600, 30, 0, 300, 450);
		set_clamps(-2, 3);
		run_ticks(150, 50, 40, 0, -1);
		// inverted clamps
		set_clamps(5, -5);
		run_ticks(150, 50, 3, 0, -1);
		set_clamps(59, 60);
		run_ticks(150, 40, 300, 0, -1);
		set_clamps(-60, -59);
		run_ticks(150, 40, 40, 0, -1);
		set_clamps(-60, 60);
		run_ticks(200, 20, 40, 100, 150);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
